@@ rtl/adl32_pkg.sv @@
// adl32_pkg: constants, widths and types shared by the checksum modules
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package adl32_pkg;

    localparam int LANES      = 8;
    localparam int DATA_BYTES = 8;
    localparam int LANE_COUNT = (LANES < DATA_BYTES) ? LANES : DATA_BYTES;

    localparam int CNT_W  = 4;
    localparam int BYTE_W = 8;
    localparam int WGT_W  = $clog2(LANE_COUNT + 1);
    localparam int WT_W   = BYTE_W + WGT_W;
    localparam int SUM_W  = $clog2(LANE_COUNT * 255 + 1);
    localparam int WSUM_W = $clog2((LANE_COUNT * (LANE_COUNT + 1) / 2) * 255 + 1);
    localparam int ACC_W  = 20;
    localparam int RED_W  = 17;

    localparam logic [CNT_W-1:0] LANE_COUNT_C = CNT_W'(LANE_COUNT);
    localparam logic [RED_W-1:0] MODULUS      = RED_W'(65521);
    localparam logic [RED_W-1:0] FOLD_MUL     = RED_W'(15);

    typedef struct packed {
        logic [BYTE_W-1:0] byte_val;
        logic [WT_W-1:0]   wtd;
    } t_lane;

    typedef struct packed {
        logic              start;
        logic [CNT_W-1:0]  count;
        logic [SUM_W-1:0]  sum;
        logic [WSUM_W-1:0] wsum;
    } t_sums;

endpackage

`default_nettype wire

@@ rtl/adl32_lane.sv @@
// adl32_lane: one byte lane, masks the byte and weights it by its distance to the item end
// depends on adl32_pkg
`timescale 1ns / 1ps
`default_nettype none

module adl32_lane
    import adl32_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire logic [CNT_W-1:0]  i_count,
    input  wire logic [CNT_W-1:0]  i_lane_idx,
    output t_lane                  o_lane
);

    logic              active;
    logic [CNT_W-1:0]  wgt;
    t_lane             n_lane;
    t_lane             r_lane;

    always_comb begin
        active          = (i_lane_idx < i_count);
        wgt             = active ? (i_count - i_lane_idx) : '0;
        n_lane.byte_val = active ? i_byte : '0;
        n_lane.wtd      = WT_W'(i_byte) * WT_W'(wgt[WGT_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

`default_nettype wire

@@ rtl/adl32_merge.sv @@
// adl32_merge: adds the lane bytes and weighted bytes into per-item sums
// depends on adl32_pkg
`timescale 1ns / 1ps
`default_nettype none

module adl32_merge
    import adl32_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic             i_start,
    input  wire logic [CNT_W-1:0] i_count,
    input  wire t_lane            i_lanes [LANE_COUNT],
    output t_sums                 o_sums
);

    t_sums n_sums;
    t_sums r_sums;

    always_comb begin
        n_sums.start = i_start;
        n_sums.count = i_count;
        n_sums.sum   = '0;
        n_sums.wsum  = '0;
        for (int k = 0; k < LANE_COUNT; k++) begin
            n_sums.sum  = n_sums.sum + SUM_W'(i_lanes[k].byte_val);
            n_sums.wsum = n_sums.wsum + WSUM_W'(i_lanes[k].wtd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sums <= n_sums;
        end
    end

    assign o_sums = r_sums;

endmodule

`default_nettype wire

@@ rtl/adl32_accum.sv @@
// adl32_accum: running low and high sums with modulo reduction, checksum register
// depends on adl32_pkg
`timescale 1ns / 1ps
`default_nettype none

module adl32_accum
    import adl32_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_upd,
    input  wire logic   i_load_out,
    input  wire t_sums  i_sums,
    output logic [31:0] o_checksum
);

    logic [15:0]      r_low;
    logic [15:0]      r_high;
    logic [31:0]      r_out;
    logic [15:0]      lo_eff;
    logic [15:0]      hi_eff;
    logic [RED_W-1:0] low_t;
    logic [RED_W-1:0] low_r;
    logic [ACC_W-1:0] high_t;
    logic [RED_W-1:0] fold;
    logic [RED_W-1:0] high_r;
    logic [15:0]      n_low;
    logic [15:0]      n_high;

    always_comb begin
        lo_eff = i_sums.start ? 16'd1 : r_low;
        hi_eff = i_sums.start ? 16'd0 : r_high;
        low_t  = RED_W'(lo_eff) + RED_W'(i_sums.sum);
        low_r  = (low_t >= MODULUS) ? (low_t - MODULUS) : low_t;
        n_low  = low_r[15:0];
        high_t = ACC_W'(hi_eff) + ACC_W'(i_sums.count) * ACC_W'(lo_eff)
               + ACC_W'(i_sums.wsum);
        // 2^16 is 15 modulo 65521
        fold   = RED_W'(high_t[ACC_W-1:16]) * FOLD_MUL + RED_W'(high_t[15:0]);
        high_r = (fold >= MODULUS) ? (fold - MODULUS) : fold;
        n_high = high_r[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= 16'd1;
            r_high <= 16'd0;
        end else if (i_upd) begin
            r_low  <= n_low;
            r_high <= n_high;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_out) begin
            r_out <= {n_high, n_low};
        end
    end

    assign o_checksum = r_out;

endmodule

`default_nettype wire

@@ rtl/adler32_checksum.sv @@
// adler32_checksum: streaming adler-32 engine, top level
// depends on adl32_pkg, adl32_lane, adl32_merge, adl32_accum
//
// input channel: i_valid / o_stall with i_start_req, i_data_bytes, i_byte_count, i_last.
// an item carries up to eight bytes, byte 0 in bits 7..0; byte counts above eight act
// as eight. i_start_req reloads the sums (low 1, high 0) before the item's bytes.
// output channel: o_valid / i_stall with o_checksum, one item per input item with i_last.
// throughput: one item per cycle while o_stall is low; the byte lanes work side by
// side and the running sums take a whole item at once through the accumulator update.
// an accepted item passes the lane, merge and output regs in turn before o_valid rises.
// the output register holds a waiting checksum while i_stall is high; input items keep
// flowing until the next last item reaches the accumulator, then the lane stage fills
// and o_stall rises.
// reset (synchronous, active low) empties the pipeline and sets low 1, high 0.
// sums persist after a last item: a new message must set i_start_req.
`timescale 1ns / 1ps
`default_nettype none

module adler32_checksum
    import adl32_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic                       i_start_req,
    input  wire logic [DATA_BYTES*8-1:0]    i_data_bytes,
    input  wire logic [CNT_W-1:0]           i_byte_count,
    input  wire logic                       i_last,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [31:0]                     o_checksum
);

    logic             r_s1_valid;
    logic             r_s1_last;
    logic             r_s1_start;
    logic [CNT_W-1:0] r_s1_count;
    logic             r_s2_valid;
    logic             r_s2_last;
    logic             r_out_valid;

    logic             s3_block;
    logic             s2_ready;
    logic             s1_ready;
    logic             s1_move;
    logic             s2_move;
    logic [CNT_W-1:0] cnt_eff;

    t_lane            lanes [LANE_COUNT];
    t_sums            sums;

    always_comb begin
        s3_block = r_s2_valid && r_s2_last && r_out_valid && i_stall;
        s2_ready = !s3_block;
        s1_ready = !r_s1_valid || s2_ready;
        s1_move  = r_s1_valid && s2_ready;
        s2_move  = r_s2_valid && !s3_block;
        cnt_eff  = (i_byte_count > LANE_COUNT_C) ? LANE_COUNT_C : i_byte_count;
    end

    assign o_stall = !s1_ready;

    // stage 1: byte lanes
    for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
        adl32_lane u_lane (
            .i_clk      (i_clk),
            .i_en       (s1_ready),
            .i_byte     (i_data_bytes[8*g +: 8]),
            .i_count    (cnt_eff),
            .i_lane_idx (CNT_W'(g)),
            .o_lane     (lanes[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready) begin
            r_s1_start <= i_start_req;
            r_s1_count <= cnt_eff;
            r_s1_last  <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    // stage 2: merge of lane results
    adl32_merge u_merge (
        .i_clk   (i_clk),
        .i_en    (s2_ready),
        .i_start (r_s1_start),
        .i_count (r_s1_count),
        .i_lanes (lanes),
        .o_sums  (sums)
    );

    always_ff @(posedge i_clk) begin
        if (s2_ready) begin
            r_s2_last <= r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= s1_move;
        end
    end

    // stage 3: running sums and checksum register
    adl32_accum u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_upd      (s2_move),
        .i_load_out (s2_move && r_s2_last),
        .i_sums     (sums),
        .o_checksum (o_checksum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_move && r_s2_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire
